/* rtl/ow_pkg.sv */
// Shared types and constants for the 1-Wire bus master.
// Used by ow_step and onewire_bus_master; no dependencies of its own.
package ow_pkg;

    localparam int unsigned BITS_PER_BYTE = 8;
    localparam int unsigned CFG_DATA_W    = 10;
    localparam int unsigned CFG_INDEX_W   = 3;
    localparam int unsigned DUR_W         = 11;

    // Command codes
    localparam logic [2:0] CMD_RESET      = 3'd0;
    localparam logic [2:0] CMD_WRITE_BIT  = 3'd1;
    localparam logic [2:0] CMD_READ_BIT   = 3'd2;
    localparam logic [2:0] CMD_WRITE_BYTE = 3'd3;
    localparam logic [2:0] CMD_READ_BYTE  = 3'd4;

    // Input kinds
    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_COMMAND = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_LOW      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESENCE_WAIT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_TAIL     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WRITE_ONE_LOW  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WRITE_ZERO_LOW = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_READ_LOW       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_READ_SAMPLE    = 3'd6;

    // Fixed recovery times in microseconds
    localparam logic [DUR_W-1:0] REC_ONE_US   = 11'd64;
    localparam logic [DUR_W-1:0] REC_ZERO_US  = 11'd10;
    localparam logic [DUR_W-1:0] READ_TAIL_US = 11'd55;
    localparam logic [DUR_W-1:0] DUR_DEFAULT  = 11'd1;

    // Configuration reset values
    localparam logic [9:0] RST_RESET_LOW      = 10'd480;
    localparam logic [7:0] RST_PRESENCE_WAIT  = 8'd70;
    localparam logic [9:0] RST_RESET_TAIL     = 10'd410;
    localparam logic [5:0] RST_WRITE_ONE_LOW  = 6'd6;
    localparam logic [6:0] RST_WRITE_ZERO_LOW = 7'd60;
    localparam logic [5:0] RST_READ_LOW       = 6'd3;
    localparam logic [5:0] RST_READ_SAMPLE    = 6'd10;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_TAIL = 4'd3,
        PH_W_LOW    = 4'd4,
        PH_W_REC    = 4'd5,
        PH_R_LOW    = 4'd6,
        PH_R_WAIT   = 4'd7,
        PH_R_TAIL   = 4'd8
    } phase_t;

    typedef struct packed {
        logic       kind;
        logic [2:0] command;
        logic [7:0] write_data;
        logic       line_level;
    } in_item_t;

    typedef struct packed {
        logic       pull_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_data;
        logic       rejected;
    } out_item_t;

    typedef struct packed {
        logic [9:0] reset_low_us;
        logic [7:0] presence_wait_us;
        logic [9:0] reset_tail_us;
        logic [5:0] write_one_low_us;
        logic [6:0] write_zero_low_us;
        logic [5:0] read_low_us;
        logic [5:0] read_sample_us;
    } cfg_t;

    typedef struct packed {
        phase_t     phase;
        logic [9:0] slot_timer;
        logic [2:0] bit_count;
        logic [7:0] shift_byte;
        logic [2:0] active_command;
        logic       presence_flag;
    } bus_state_t;

endpackage

/* rtl/ow_step.sv */
// Per-beat update of the 1-Wire master: next bus state and the result item.
// Depends on ow_pkg for the state, item and configuration types.
module ow_step (
    input  ow_pkg::bus_state_t st,
    input  ow_pkg::in_item_t   item,
    input  ow_pkg::cfg_t       cfg,
    output ow_pkg::bus_state_t st_next,
    output ow_pkg::out_item_t  res
);

    logic                    finish;
    logic                    rejected;
    logic [ow_pkg::DUR_W-1:0] dur;
    logic [ow_pkg::DUR_W-1:0] tick_count;
    logic                    byte_cmd;

    // Length of the current phase in ticks
    always_comb begin
        unique case (st.phase)
            ow_pkg::PH_RST_LOW:  dur = {1'b0, cfg.reset_low_us};
            ow_pkg::PH_RST_WAIT: dur = {3'b000, cfg.presence_wait_us};
            ow_pkg::PH_RST_TAIL: dur = {1'b0, cfg.reset_tail_us};
            ow_pkg::PH_W_LOW:    dur = st.shift_byte[0] ? {5'b0, cfg.write_one_low_us}
                                                        : {4'b0, cfg.write_zero_low_us};
            ow_pkg::PH_W_REC:    dur = st.shift_byte[0] ? ow_pkg::REC_ONE_US
                                                        : ow_pkg::REC_ZERO_US;
            ow_pkg::PH_R_LOW:    dur = {5'b0, cfg.read_low_us};
            ow_pkg::PH_R_WAIT:   dur = {5'b0, cfg.read_sample_us};
            ow_pkg::PH_R_TAIL:   dur = ow_pkg::READ_TAIL_US;
            default:             dur = ow_pkg::DUR_DEFAULT;
        endcase
    end

    assign tick_count = {1'b0, st.slot_timer} + ow_pkg::DUR_W'(1);
    assign byte_cmd   = (st.active_command == ow_pkg::CMD_WRITE_BYTE) ||
                        (st.active_command == ow_pkg::CMD_READ_BYTE);

    // Next state
    always_comb begin
        st_next  = st;
        finish   = 1'b0;
        rejected = 1'b0;
        if (item.kind == ow_pkg::KIND_COMMAND) begin
            if (st.phase != ow_pkg::PH_IDLE || item.command > ow_pkg::CMD_READ_BYTE) begin
                rejected = 1'b1;
            end else begin
                st_next.active_command = item.command;
                st_next.slot_timer     = '0;
                st_next.bit_count      = '0;
                st_next.shift_byte     = '0;
                unique case (item.command)
                    ow_pkg::CMD_RESET: begin
                        st_next.phase = ow_pkg::PH_RST_LOW;
                    end
                    ow_pkg::CMD_WRITE_BIT, ow_pkg::CMD_WRITE_BYTE: begin
                        st_next.phase      = ow_pkg::PH_W_LOW;
                        st_next.shift_byte = item.write_data;
                    end
                    default: begin
                        st_next.phase = ow_pkg::PH_R_LOW;
                    end
                endcase
            end
        end else if (st.phase != ow_pkg::PH_IDLE) begin
            if (tick_count < dur) begin
                st_next.slot_timer = tick_count[9:0];
            end else begin
                st_next.slot_timer = '0;
                unique case (st.phase)
                    ow_pkg::PH_RST_LOW: begin
                        st_next.phase = ow_pkg::PH_RST_WAIT;
                    end
                    ow_pkg::PH_RST_WAIT: begin
                        st_next.presence_flag = ~item.line_level;
                        if (cfg.reset_tail_us == '0) begin
                            finish = 1'b1;
                        end else begin
                            st_next.phase = ow_pkg::PH_RST_TAIL;
                        end
                    end
                    ow_pkg::PH_W_LOW: begin
                        st_next.phase = ow_pkg::PH_W_REC;
                    end
                    ow_pkg::PH_R_LOW: begin
                        st_next.phase = ow_pkg::PH_R_WAIT;
                    end
                    ow_pkg::PH_R_WAIT: begin
                        if (st.active_command == ow_pkg::CMD_READ_BIT) begin
                            st_next.shift_byte = {7'b0, item.line_level};
                        end else begin
                            st_next.shift_byte = {item.line_level, st.shift_byte[7:1]};
                        end
                        st_next.phase = ow_pkg::PH_R_TAIL;
                    end
                    ow_pkg::PH_W_REC, ow_pkg::PH_R_TAIL: begin
                        // advance to the next slot of a byte, or finish
                        if (byte_cmd &&
                            st.bit_count < 3'(ow_pkg::BITS_PER_BYTE - 1)) begin
                            st_next.bit_count = st.bit_count + 3'd1;
                            if (st.active_command == ow_pkg::CMD_WRITE_BYTE) begin
                                st_next.shift_byte = {1'b0, st.shift_byte[7:1]};
                                st_next.phase      = ow_pkg::PH_W_LOW;
                            end else begin
                                st_next.phase = ow_pkg::PH_R_LOW;
                            end
                        end else begin
                            finish = 1'b1;
                        end
                    end
                    default: begin
                        finish = 1'b1;
                    end
                endcase
            end
            if (finish) begin
                st_next.phase = ow_pkg::PH_IDLE;
            end
        end
    end

    // Result item from the updated state
    always_comb begin
        res.pull_low  = (st_next.phase == ow_pkg::PH_RST_LOW) ||
                        (st_next.phase == ow_pkg::PH_W_LOW) ||
                        (st_next.phase == ow_pkg::PH_R_LOW);
        res.busy_res  = (st_next.phase != ow_pkg::PH_IDLE);
        res.done_res  = finish;
        res.presence  = st_next.presence_flag;
        res.rejected  = rejected;
        if (finish && (st.active_command == ow_pkg::CMD_READ_BIT ||
                       st.active_command == ow_pkg::CMD_READ_BYTE)) begin
            res.read_data = st_next.shift_byte;
        end else begin
            res.read_data = '0;
        end
    end

endmodule

/* rtl/onewire_bus_master.sv */
// 1-Wire bus master top level: configuration registers, bus state and result register.
// Depends on ow_pkg and ow_step.
//
// Usage:
//   s_valid/s_ready/s_data carry input beats. A beat of kind tick stands for
//   one microsecond and carries the sampled line level; a beat of kind command
//   starts a reset with presence detect, a bit or a byte transfer (LSB first).
//   m_valid/m_ready/m_data carry one result beat per input beat: pull_low for
//   the open-drain pin, busy, done, presence, read data and a reject flag.
//   cfg_we/cfg_index/cfg_wdata write the seven timing registers, one per
//   clock, with no wait; write only while the master is idle.
// Timing:
//   m_valid rises in the cycle after an input beat is accepted. One beat is
//   taken every cycle unless the receiver stalls: the state update is a single
//   pass of ow_step between the bus state registers and the result register.
//   When the receiver stalls, the result register holds and s_ready drops
//   only while a result is waiting and m_ready is low.
// Reset:
//   aresetn (synchronous, active low) idles the bus, clears the state and
//   the result register and loads the default timing values.
module onewire_bus_master (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  ow_pkg::in_item_t                  s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output ow_pkg::out_item_t                 m_data,
    input  logic                              cfg_we,
    input  logic [ow_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ow_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    ow_pkg::cfg_t       cfg_reg;
    ow_pkg::bus_state_t state_reg;
    ow_pkg::bus_state_t state_next;
    ow_pkg::out_item_t  res_next;
    ow_pkg::out_item_t  m_data_reg;
    logic               m_valid_reg;
    logic               s_beat;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_beat  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Configuration registers; bits above a register's width are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_low_us      <= ow_pkg::RST_RESET_LOW;
            cfg_reg.presence_wait_us  <= ow_pkg::RST_PRESENCE_WAIT;
            cfg_reg.reset_tail_us     <= ow_pkg::RST_RESET_TAIL;
            cfg_reg.write_one_low_us  <= ow_pkg::RST_WRITE_ONE_LOW;
            cfg_reg.write_zero_low_us <= ow_pkg::RST_WRITE_ZERO_LOW;
            cfg_reg.read_low_us       <= ow_pkg::RST_READ_LOW;
            cfg_reg.read_sample_us    <= ow_pkg::RST_READ_SAMPLE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ow_pkg::REG_RESET_LOW:      cfg_reg.reset_low_us      <= cfg_wdata;
                ow_pkg::REG_PRESENCE_WAIT:  cfg_reg.presence_wait_us  <= cfg_wdata[7:0];
                ow_pkg::REG_RESET_TAIL:     cfg_reg.reset_tail_us     <= cfg_wdata;
                ow_pkg::REG_WRITE_ONE_LOW:  cfg_reg.write_one_low_us  <= cfg_wdata[5:0];
                ow_pkg::REG_WRITE_ZERO_LOW: cfg_reg.write_zero_low_us <= cfg_wdata[6:0];
                ow_pkg::REG_READ_LOW:       cfg_reg.read_low_us       <= cfg_wdata[5:0];
                ow_pkg::REG_READ_SAMPLE:    cfg_reg.read_sample_us    <= cfg_wdata[5:0];
                default: begin
                end
            endcase
        end
    end

    ow_step u_step (
        .st      (state_reg),
        .item    (s_data),
        .cfg     (cfg_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase          <= ow_pkg::PH_IDLE;
            state_reg.slot_timer     <= '0;
            state_reg.bit_count      <= '0;
            state_reg.shift_byte     <= '0;
            state_reg.active_command <= ow_pkg::CMD_RESET;
            state_reg.presence_flag  <= 1'b0;
        end else if (s_beat) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_beat) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload; hold while stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_data_reg <= '0;
        end else if (s_beat) begin
            m_data_reg <= res_next;
        end
    end

    a_beat_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat |=> m_valid_reg)
        else $error("accepted beat produced no result");

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.done_res |-> !m_data_reg.busy_res && !m_data_reg.rejected)
        else $error("done result while still busy or rejected");

    a_drive_implies_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.pull_low |-> m_data_reg.busy_res)
        else $error("line driven low while idle");

    a_read_data_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.read_data != 8'd0 |-> m_data_reg.done_res)
        else $error("read data outside a completing beat");

endmodule
